>>> sv/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/wrp_pkg.sv
// Shared types and constants for the RIFF/WAVE header parser.
// No dependencies.
package wrp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] RST_CHANNELS    = 16'd2;
    localparam logic [31:0] RST_SAMPLE_RATE = 32'd44100;
    localparam logic [31:0] FMT_BODY_LEN    = 32'd16;
    localparam logic [15:0] PCM_FORMAT      = 16'd1;
    localparam logic [15:0] PCM_BITS        = 16'd16;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR = 3'd1;
    localparam logic [2:0] ST_NO_RIFF   = 3'd2;
    localparam logic [2:0] ST_NO_WAVE   = 3'd3;
    localparam logic [2:0] ST_FMT_TRUNC = 3'd4;
    localparam logic [2:0] ST_NOT_PCM   = 3'd5;
    localparam logic [2:0] ST_NOT_16BIT = 3'd6;
    localparam logic [2:0] ST_NO_DATA   = 3'd7;

    localparam logic CFG_CHANNELS = 1'b0;
    localparam logic CFG_RATE     = 1'b1;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_CHUNK  = 4'b0010,
        PH_FMT    = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_of_file;
        logic       last_of_file;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data_offset;
        logic [31:0] data_size;
        logic [15:0] channel_count;
        logic [31:0] audio_rate;
    } result_t;

endpackage

>>> sv/wrp_channels.sv
// Valid/ready channel interfaces for file bytes and parse results.
// No dependencies.
interface wrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       first_of_file;
    logic       last_of_file;

    modport source (output valid, output file_byte, output first_of_file,
                    output last_of_file, input ready);
    modport sink (input valid, input file_byte, input first_of_file,
                  input last_of_file, output ready);
endinterface

interface wrp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [15:0] channel_count;
    logic [31:0] audio_rate;

    modport source (output valid, output status, output data_offset,
                    output data_size, output channel_count, output audio_rate,
                    input ready);
    modport sink (input valid, input status, input data_offset,
                  input data_size, input channel_count, input audio_rate,
                  output ready);
endinterface

>>> sv/wrp_in_stage.sv
// Input register: holds one file byte item until the parser takes it.
// Depends on wrp_pkg.
module wrp_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  wrp_pkg::byte_item_t in_item,
    output logic               in_ready,
    input  logic               take,
    output logic               held_valid,
    output wrp_pkg::byte_item_t held_item
);

    logic                held_valid_reg;
    logic                held_valid_next;
    wrp_pkg::byte_item_t held_item_reg;

    assign in_ready   = !held_valid_reg || take;
    assign held_valid = held_valid_reg;
    assign held_item  = held_item_reg;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (in_ready)
        begin
            held_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            held_item_reg <= in_item;
        end
    end

endmodule

>>> sv/wrp_parse_core.sv
// Parser state and per-byte update; holds the default registers.
// Depends on wrp_pkg.
module wrp_parse_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  wrp_pkg::byte_item_t item,
    input  logic                out_space,
    output logic                take,
    output logic                res_valid,
    output wrp_pkg::result_t    res,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

    wrp_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  count_reg, count_next;
    logic [63:0] shift_reg, shift_next;
    logic [31:0] clen_reg, clen_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] pos_reg, pos_next;
    logic [15:0] lat_ch_reg, lat_ch_next;
    logic [31:0] lat_rate_reg, lat_rate_next;
    logic [15:0] fmt_word_reg, fmt_word_next;
    logic        done_reg, done_next;
    logic        ch_fmt_reg, ch_fmt_next;
    logic        rate_fmt_reg, rate_fmt_next;
    logic [15:0] def_ch_reg, def_ch_next;
    logic [31:0] def_rate_reg, def_rate_next;

    logic        fire;
    logic        has_st;
    logic [2:0]  st;
    logic [31:0] offset;
    logic [31:0] size;
    logic [4:0]  i;
    logic [7:0]  b;

    assign fire = item_valid && out_space;
    assign take = fire;
    assign b    = item.file_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        shift_next    = shift_reg;
        clen_next     = clen_reg;
        skip_next     = skip_reg;
        pos_next      = pos_reg;
        lat_ch_next   = lat_ch_reg;
        lat_rate_next = lat_rate_reg;
        fmt_word_next = fmt_word_reg;
        done_next     = done_reg;
        ch_fmt_next   = ch_fmt_reg;
        rate_fmt_next = rate_fmt_reg;
        def_ch_next   = def_ch_reg;
        def_rate_next = def_rate_reg;
        has_st        = 1'b0;
        st            = wrp_pkg::ST_OK;
        offset        = '0;
        size          = '0;

        if (fire && item.first_of_file)
        begin
            phase_next    = wrp_pkg::PH_HEADER;
            count_next    = '0;
            shift_next    = '0;
            clen_next     = '0;
            skip_next     = '0;
            pos_next      = '0;
            lat_ch_next   = def_ch_reg;
            lat_rate_next = def_rate_reg;
            fmt_word_next = '0;
            done_next     = 1'b0;
            ch_fmt_next   = 1'b0;
            rate_fmt_next = 1'b0;
        end

        // i reads count_next before the byte updates it (first-of-file applied)
        i = count_next;
        if (fire && !done_next)
        begin
            pos_next   = pos_next + 32'd1;
            count_next = i + 5'd1;
            unique case (phase_next)
                wrp_pkg::PH_HEADER:
                begin
                    if (i < 5'd4)
                    begin
                        clen_next[{i[1:0], 3'b000} +: 8] =
                            clen_next[{i[1:0], 3'b000} +: 8] | b;
                    end
                    else if (i >= 5'd8 && i < 5'd12)
                    begin
                        shift_next[{1'b0, i[1:0], 3'b000} +: 8] =
                            shift_next[{1'b0, i[1:0], 3'b000} +: 8] | b;
                    end
                    if (i == 5'd11)
                    begin
                        if (clen_next != wrp_pkg::TAG_RIFF)
                        begin
                            has_st = 1'b1;
                            st     = wrp_pkg::ST_NO_RIFF;
                        end
                        else if (shift_next[31:0] != wrp_pkg::TAG_WAVE)
                        begin
                            has_st = 1'b1;
                            st     = wrp_pkg::ST_NO_WAVE;
                        end
                        else
                        begin
                            phase_next = wrp_pkg::PH_CHUNK;
                            count_next = '0;
                            shift_next = '0;
                        end
                    end
                end
                wrp_pkg::PH_CHUNK:
                begin
                    shift_next[{i[2:0], 3'b000} +: 8] =
                        shift_next[{i[2:0], 3'b000} +: 8] | b;
                    if (i == 5'd7)
                    begin
                        clen_next = shift_next[63:32];
                        if (shift_next[31:0] == wrp_pkg::TAG_DATA)
                        begin
                            has_st = 1'b1;
                            st     = wrp_pkg::ST_OK;
                            offset = pos_next;
                            size   = shift_next[63:32];
                        end
                        else if (shift_next[31:0] == wrp_pkg::TAG_FMT)
                        begin
                            phase_next    = wrp_pkg::PH_FMT;
                            count_next    = '0;
                            shift_next    = '0;
                            fmt_word_next = '0;
                        end
                        else if (shift_next[63:32] == 32'd0)
                        begin
                            count_next = '0;
                            shift_next = '0;
                        end
                        else
                        begin
                            skip_next  = shift_next[63:32];
                            phase_next = wrp_pkg::PH_SKIP;
                            count_next = '0;
                        end
                    end
                end
                wrp_pkg::PH_FMT:
                begin
                    if (i < 5'd8)
                    begin
                        shift_next[{i[2:0], 3'b000} +: 8] =
                            shift_next[{i[2:0], 3'b000} +: 8] | b;
                    end
                    else if (i == 5'd14)
                    begin
                        fmt_word_next = {8'd0, b};
                    end
                    else if (i == 5'd15)
                    begin
                        fmt_word_next = fmt_word_next | {b, 8'd0};
                    end
                    if (i == 5'd15)
                    begin
                        lat_ch_next = shift_next[31:16];
                        ch_fmt_next = 1'b1;
                        if (shift_next[15:0] != wrp_pkg::PCM_FORMAT)
                        begin
                            has_st = 1'b1;
                            st     = wrp_pkg::ST_NOT_PCM;
                        end
                        else if (fmt_word_next != wrp_pkg::PCM_BITS)
                        begin
                            has_st = 1'b1;
                            st     = wrp_pkg::ST_NOT_16BIT;
                        end
                        else
                        begin
                            lat_rate_next = shift_next[63:32];
                            rate_fmt_next = 1'b1;
                            if (clen_next > wrp_pkg::FMT_BODY_LEN)
                            begin
                                skip_next  = clen_next - wrp_pkg::FMT_BODY_LEN;
                                phase_next = wrp_pkg::PH_SKIP;
                                count_next = '0;
                            end
                            else
                            begin
                                phase_next = wrp_pkg::PH_CHUNK;
                                count_next = '0;
                                shift_next = '0;
                            end
                        end
                    end
                end
                wrp_pkg::PH_SKIP:
                begin
                    count_next = i;
                    if (skip_next != 32'd0)
                    begin
                        skip_next = skip_next - 32'd1;
                    end
                    if (skip_next == 32'd0)
                    begin
                        phase_next = wrp_pkg::PH_CHUNK;
                        count_next = '0;
                        shift_next = '0;
                    end
                end
                default:
                begin
                    count_next = i;
                end
            endcase

            if (!has_st && item.last_of_file)
            begin
                has_st = 1'b1;
                if (phase_next == wrp_pkg::PH_HEADER)
                begin
                    st = wrp_pkg::ST_SHORT_HDR;
                end
                else if (phase_next == wrp_pkg::PH_FMT)
                begin
                    st = wrp_pkg::ST_FMT_TRUNC;
                end
                else
                begin
                    st = wrp_pkg::ST_NO_DATA;
                end
            end
            if (has_st)
            begin
                done_next = 1'b1;
            end
        end

        // configuration writes must arrive only while idle; the block does not enforce it
        if (cfg_we)
        begin
            if (cfg_index == wrp_pkg::CFG_CHANNELS)
            begin
                def_ch_next = cfg_data[15:0];
                if (!ch_fmt_reg)
                begin
                    lat_ch_next = cfg_data[15:0];
                end
            end
            else
            begin
                def_rate_next = cfg_data;
                if (!rate_fmt_reg)
                begin
                    lat_rate_next = cfg_data;
                end
            end
        end
    end

    assign res_valid         = fire && has_st;
    assign res.status        = st;
    assign res.data_offset   = offset;
    assign res.data_size     = size;
    assign res.channel_count = lat_ch_next;
    assign res.audio_rate    = lat_rate_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= wrp_pkg::PH_HEADER;
            count_reg    <= '0;
            shift_reg    <= '0;
            clen_reg     <= '0;
            skip_reg     <= '0;
            pos_reg      <= '0;
            lat_ch_reg   <= wrp_pkg::RST_CHANNELS;
            lat_rate_reg <= wrp_pkg::RST_SAMPLE_RATE;
            fmt_word_reg <= '0;
            done_reg     <= 1'b0;
            ch_fmt_reg   <= 1'b0;
            rate_fmt_reg <= 1'b0;
            def_ch_reg   <= wrp_pkg::RST_CHANNELS;
            def_rate_reg <= wrp_pkg::RST_SAMPLE_RATE;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            shift_reg    <= shift_next;
            clen_reg     <= clen_next;
            skip_reg     <= skip_next;
            pos_reg      <= pos_next;
            lat_ch_reg   <= lat_ch_next;
            lat_rate_reg <= lat_rate_next;
            fmt_word_reg <= fmt_word_next;
            done_reg     <= done_next;
            ch_fmt_reg   <= ch_fmt_next;
            rate_fmt_reg <= rate_fmt_next;
            def_ch_reg   <= def_ch_next;
            def_rate_reg <= def_rate_next;
        end
    end

endmodule

>>> sv/wrp_out_stage.sv
// Result register: holds one result item until the receiver takes it.
// Depends on wrp_pkg.
module wrp_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  wrp_pkg::result_t load_data,
    output logic             space,
    output logic             out_valid,
    output wrp_pkg::result_t out_data,
    input  logic             out_ready
);

    logic             valid_reg;
    logic             valid_next;
    wrp_pkg::result_t data_reg;

    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (space)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && space)
        begin
            data_reg <= load_data;
        end
    end

endmodule

>>> sv/wav_riff_header_parser_top.sv
// RIFF/WAVE header parser: takes a file one byte item at a time, reports at
// most one result item per file; depends on wrp_pkg, wrp_channels, stages.
//
// in_ch carries file bytes with first_of_file / last_of_file marks; out_ch
// carries one result per file (status, data offset and size, channel count,
// sample rate). Items move when valid and ready are both high.
// Each byte goes into an input register, is parsed there once the result
// register has space and, if it decides the file, lands in the result
// register. One byte per cycle sustained while the result register has
// space; the per-byte parser update is the only step between the two registers.
// When the receiver stalls, the result register holds and the input
// register keeps one more byte, then in_ch.ready drops until out_ch drains.
// Bytes after the deciding one are accepted and dropped until first_of_file.
// Reset clears the parse state and loads the defaults (2 channels, 44100 Hz).
// cfg_we writes register cfg_index (0 channels, 1 sample rate) from cfg_data;
// the user writes it only while the block is idle, which is not enforced. It
// also updates the reported value unless a fmt chunk of this file supplied it.
module wav_riff_header_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    wrp_byte_if.sink    in_ch,
    wrp_result_if.source out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    wrp_pkg::byte_item_t in_item;
    wrp_pkg::byte_item_t held_item;
    wrp_pkg::result_t    res;
    wrp_pkg::result_t    out_data;
    logic                held_valid;
    logic                take;
    logic                res_valid;
    logic                space;

    assign in_item.file_byte     = in_ch.file_byte;
    assign in_item.first_of_file = in_ch.first_of_file;
    assign in_item.last_of_file  = in_ch.last_of_file;

    wrp_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_item    (in_item),
        .in_ready   (in_ch.ready),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    wrp_parse_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (held_valid),
        .item       (held_item),
        .out_space  (space),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    wrp_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res),
        .space     (space),
        .out_valid (out_ch.valid),
        .out_data  (out_data),
        .out_ready (out_ch.ready)
    );

    assign out_ch.status        = out_data.status;
    assign out_ch.data_offset   = out_data.data_offset;
    assign out_ch.data_size     = out_data.data_size;
    assign out_ch.channel_count = out_data.channel_count;
    assign out_ch.audio_rate    = out_data.audio_rate;

endmodule

>>> sv/wrp_checker.sv
// Port-level checks for the RIFF/WAVE header parser, bound to the top level.
// Depends on wrp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wrp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [31:0] data_offset,
    input logic [31:0] data_size
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(status))
    `ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && status != wrp_pkg::ST_OK, data_offset == 32'd0 && data_size == 32'd0)
    `ASSERT_IMPL(a_no_stall, clk, rst_n, !out_valid || out_ready, in_ready)

endmodule

bind wav_riff_header_parser_top wrp_checker u_wrp_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (out_ch.status),
    .data_offset (out_ch.data_offset),
    .data_size   (out_ch.data_size)
);

>>> dv/wav_riff_header_parser_top_tb.sv
// Testbench for wav_riff_header_parser_top: directed and random byte streams,
// with a built-in parser model that predicts each file's result item.
// Depends on wrp_pkg, wrp_channels and the parser RTL.
module wav_riff_header_parser_top_tb;
    import wrp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    wrp_byte_if   in_ch();
    wrp_result_if out_ch();

    wav_riff_header_parser_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    byte_item_t  pending_bytes[$];
    result_t     expected_results[$];
    logic [7:0]  file_buf[$];
    int unsigned bytes_queued;
    int unsigned bytes_accepted;
    int unsigned failures;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        byte_taken;
    byte_item_t  next_byte;
    byte_item_t  seen_byte;
    result_t     want;

    // parser model state
    phase_t      hdr_phase;
    logic [4:0]  step_count;
    logic [63:0] gather;
    logic [31:0] chunk_size;
    logic [31:0] skip_left;
    logic [31:0] file_pos;
    logic [15:0] cur_channels;
    logic [31:0] cur_rate;
    logic [15:0] bits_field;
    logic        file_done;
    logic        channels_from_fmt;
    logic        rate_from_fmt;
    logic [15:0] reg_channels;
    logic [31:0] reg_rate;

    function automatic void restart_file();
        hdr_phase = PH_HEADER;
        step_count = '0;
        gather = '0;
        chunk_size = '0;
        skip_left = '0;
        file_pos = '0;
        cur_channels = reg_channels;
        cur_rate = reg_rate;
        bits_field = '0;
        file_done = 1'b0;
        channels_from_fmt = 1'b0;
        rate_from_fmt = 1'b0;
    endfunction

    function automatic void enter_chunk_header();
        hdr_phase = PH_CHUNK;
        step_count = '0;
        gather = '0;
    endfunction

    function automatic void parse_byte(input byte_item_t it);
        result_t    res;
        logic       decided;
        logic [2:0] code;
        logic [4:0] n;
        decided = 1'b0;
        code = ST_OK;
        if (it.first_of_file)
            restart_file();
        if (file_done)
            return;
        file_pos = file_pos + 32'd1;
        n = step_count;
        case (hdr_phase)
            PH_HEADER:
            begin
                if (n < 4)
                    chunk_size[8*n +: 8] = it.file_byte;
                else if (n >= 8 && n < 12)
                    gather[8*(n-8) +: 8] = it.file_byte;
                step_count = n + 5'd1;
                if (step_count >= 12)
                begin
                    decided = 1'b1;
                    if (chunk_size != TAG_RIFF)
                        code = ST_NO_RIFF;
                    else if (gather[31:0] != TAG_WAVE)
                        code = ST_NO_WAVE;
                    else
                    begin
                        decided = 1'b0;
                        enter_chunk_header();
                    end
                end
            end
            PH_CHUNK:
            begin
                gather[8*n[2:0] +: 8] = it.file_byte;
                step_count = n + 5'd1;
                if (step_count >= 8)
                begin
                    chunk_size = gather[63:32];
                    if (gather[31:0] == TAG_DATA)
                    begin
                        decided = 1'b1;
                        code = ST_OK;
                    end
                    else if (gather[31:0] == TAG_FMT)
                    begin
                        hdr_phase = PH_FMT;
                        step_count = '0;
                        gather = '0;
                        bits_field = '0;
                    end
                    else if (chunk_size == 0)
                        enter_chunk_header();
                    else
                    begin
                        skip_left = chunk_size;
                        hdr_phase = PH_SKIP;
                        step_count = '0;
                    end
                end
            end
            PH_FMT:
            begin
                if (n < 8)
                    gather[8*n +: 8] = it.file_byte;
                else if (n == 14)
                    bits_field = {8'h00, it.file_byte};
                else if (n == 15)
                    bits_field[15:8] = it.file_byte;
                step_count = n + 5'd1;
                if (step_count >= 16)
                begin
                    cur_channels = gather[31:16];
                    channels_from_fmt = 1'b1;
                    if (gather[15:0] != PCM_FORMAT)
                    begin
                        decided = 1'b1;
                        code = ST_NOT_PCM;
                    end
                    else if (bits_field != PCM_BITS)
                    begin
                        decided = 1'b1;
                        code = ST_NOT_16BIT;
                    end
                    else
                    begin
                        cur_rate = gather[63:32];
                        rate_from_fmt = 1'b1;
                        if (chunk_size > FMT_BODY_LEN)
                        begin
                            skip_left = chunk_size - FMT_BODY_LEN;
                            hdr_phase = PH_SKIP;
                            step_count = '0;
                        end
                        else
                            enter_chunk_header();
                    end
                end
            end
            default:
            begin
                if (skip_left > 0)
                    skip_left = skip_left - 32'd1;
                if (skip_left == 0)
                    enter_chunk_header();
            end
        endcase

        if (!decided && it.last_of_file)
        begin
            decided = 1'b1;
            if (hdr_phase == PH_HEADER)
                code = ST_SHORT_HDR;
            else if (hdr_phase == PH_FMT)
                code = ST_FMT_TRUNC;
            else
                code = ST_NO_DATA;
        end
        if (!decided)
            return;

        file_done = 1'b1;
        res.status = code;
        res.data_offset = (code == ST_OK) ? file_pos : 32'd0;
        res.data_size = (code == ST_OK) ? chunk_size : 32'd0;
        res.channel_count = cur_channels;
        res.audio_rate = cur_rate;
        expected_results.push_back(res);
    endfunction

    // stimulus building
    function automatic void queue_byte(input logic [7:0] b, input logic f, input logic l);
        byte_item_t it;
        it.file_byte = b;
        it.first_of_file = f;
        it.last_of_file = l;
        pending_bytes.push_back(it);
        bytes_queued++;
    endfunction

    // keep == 0 sends the whole file
    function automatic void emit_file(input logic f, input logic l, input int keep);
        int cnt;
        cnt = (keep == 0) ? file_buf.size() : keep;
        for (int i = 0; i < cnt; i++)
            queue_byte(file_buf[i], f && i == 0, l && i == cnt - 1);
        file_buf.delete();
    endfunction

    function automatic void put_half(input logic [15:0] h);
        file_buf.push_back(h[7:0]);
        file_buf.push_back(h[15:8]);
    endfunction

    function automatic void put_word(input logic [31:0] w);
        put_half(w[15:0]);
        put_half(w[31:16]);
    endfunction

    function automatic void put_chunk_head(input logic [31:0] id, input logic [31:0] size);
        put_word(id);
        put_word(size);
    endfunction

    function automatic void put_header(input logic [31:0] riff_tag, input logic [31:0] wave_tag);
        put_word(riff_tag);
        put_word($urandom);
        put_word(wave_tag);
    endfunction

    function automatic void put_fmt(input logic [31:0] size, input logic [15:0] code,
                                    input logic [15:0] chans, input logic [31:0] rate,
                                    input logic [15:0] bits_code);
        put_chunk_head(TAG_FMT, size);
        put_half(code);
        put_half(chans);
        put_word(rate);
        put_word($urandom);
        put_half(16'($urandom));
        put_half(bits_code);
        if (size > FMT_BODY_LEN)
            repeat (size - FMT_BODY_LEN) file_buf.push_back(8'($urandom));
    endfunction

    // unknown chunk IDs, often one bit away from a known tag
    function automatic logic [31:0] odd_chunk_id();
        logic [31:0] id;
        case ($urandom_range(3))
            0: id = TAG_FMT ^ (32'h1 << $urandom_range(31));
            1: id = TAG_DATA ^ (32'h1 << $urandom_range(31));
            default: id = $urandom;
        endcase
        if (id == TAG_FMT || id == TAG_DATA)
            id = id ^ 32'h80;
        return id;
    endfunction

    function automatic int unsigned small_size();
        return ($urandom_range(9) < 7) ? $urandom_range(0, 4) : $urandom_range(5, 40);
    endfunction

    function automatic void put_unknown_chunk(input int unsigned size);
        put_chunk_head(odd_chunk_id(), size);
        repeat (size) file_buf.push_back(8'($urandom));
    endfunction

    function automatic void gen_random_file();
        int          kind;
        int          keep;
        int          pick;
        logic [31:0] riff_tag;
        logic [31:0] wave_tag;
        logic [31:0] fmt_size;
        logic [15:0] code;
        logic [15:0] bits_code;
        logic        mark_first;
        logic        mark_last;
        kind = $urandom_range(99);
        if (kind < 6)
        begin
            repeat ($urandom_range(1, 16))
                queue_byte(8'($urandom), $urandom_range(7) == 0, $urandom_range(5) == 0);
            return;
        end
        riff_tag = TAG_RIFF;
        wave_tag = TAG_WAVE;
        code = PCM_FORMAT;
        bits_code = PCM_BITS;
        if (kind < 12 || (kind >= 18 && kind < 20))
            riff_tag = riff_tag ^ (32'h1 << $urandom_range(31));
        if (kind >= 12 && kind < 20)
            wave_tag = wave_tag ^ (32'h1 << $urandom_range(31));
        put_header(riff_tag, wave_tag);
        repeat ($urandom_range(0, 2)) put_unknown_chunk(small_size());
        if ($urandom_range(99) < 85)
        begin
            if (kind >= 20 && kind < 23)
            begin
                code = 16'($urandom);
                if (code == PCM_FORMAT)
                    code = 16'h0003;
            end
            else if (kind >= 23 && kind < 26)
            begin
                bits_code = 16'($urandom);
                if (bits_code == PCM_BITS)
                    bits_code = 16'd24;
            end
            pick = $urandom_range(9);
            if (pick < 6)
                fmt_size = FMT_BODY_LEN;
            else if (pick < 9)
                fmt_size = FMT_BODY_LEN + $urandom_range(1, 6);
            else
                fmt_size = $urandom_range(0, 15);
            put_fmt(fmt_size, code, 16'($urandom), $urandom, bits_code);
        end
        repeat ($urandom_range(0, 1)) put_unknown_chunk(small_size());
        if (kind >= 26 && kind < 32)
        begin
            put_chunk_head(odd_chunk_id(), $urandom);
            repeat ($urandom_range(0, 4)) file_buf.push_back(8'($urandom));
        end
        else
        begin
            put_chunk_head(TAG_DATA, $urandom);
            repeat ($urandom_range(0, 2)) file_buf.push_back(8'($urandom));
        end
        keep = 0;
        if (kind >= 32 && kind < 47)
            keep = $urandom_range(1, file_buf.size());
        mark_first = $urandom_range(99) >= 3;
        mark_last = (kind >= 26 && kind < 47) || $urandom_range(99) >= 5;
        emit_file(mark_first, mark_last, keep);
    endfunction

    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_regs(input logic [15:0] chans, input logic [31:0] rate);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CHANNELS;
        cfg_data <= {16'h0000, chans};
        @(negedge clk);
        cfg_index <= CFG_RATE;
        cfg_data <= rate;
        @(negedge clk);
        cfg_we <= 1'b0;
        reg_channels = chans;
        reg_rate = rate;
        if (!channels_from_fmt)
            cur_channels = chans;
        if (!rate_from_fmt)
            cur_rate = rate;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || byte_taken)
        begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_byte = pending_bytes.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.file_byte <= next_byte.file_byte;
                in_ch.first_of_file <= next_byte.first_of_file;
                in_ch.last_of_file <= next_byte.last_of_file;
            end
            else
                in_ch.valid <= 1'b0;
        end
        out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            byte_taken = 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with none expected: status %0d", out_ch.status);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        failures++;
                    end
                    if (out_ch.data_offset !== want.data_offset)
                    begin
                        $error("data_offset: expected %0d, got %0d",
                               want.data_offset, out_ch.data_offset);
                        failures++;
                    end
                    if (out_ch.data_size !== want.data_size)
                    begin
                        $error("data_size: expected 0x%08h, got 0x%08h",
                               want.data_size, out_ch.data_size);
                        failures++;
                    end
                    if (out_ch.channel_count !== want.channel_count)
                    begin
                        $error("channel_count: expected %0d, got %0d",
                               want.channel_count, out_ch.channel_count);
                        failures++;
                    end
                    if (out_ch.audio_rate !== want.audio_rate)
                    begin
                        $error("audio_rate: expected %0d, got %0d",
                               want.audio_rate, out_ch.audio_rate);
                        failures++;
                    end
                end
            end
            byte_taken = in_ch.valid && in_ch.ready;
            if (byte_taken)
            begin
                bytes_accepted++;
                seen_byte.file_byte = in_ch.file_byte;
                seen_byte.first_of_file = in_ch.first_of_file;
                seen_byte.last_of_file = in_ch.last_of_file;
                parse_byte(seen_byte);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int unsigned start;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CHANNELS;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.file_byte = '0;
        in_ch.first_of_file = 1'b0;
        in_ch.last_of_file = 1'b0;
        out_ch.ready = 1'b0;
        byte_taken = 1'b0;
        bytes_queued = 0;
        bytes_accepted = 0;
        failures = 0;
        send_idle_pct = 35;
        recv_idle_pct = 72;
        reg_channels = RST_CHANNELS;
        reg_rate = RST_SAMPLE_RATE;
        restart_file();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // stream with no first mark, data header ends on the last byte
        put_header(TAG_RIFF, TAG_WAVE);
        put_chunk_head(TAG_DATA, 32'd0);
        emit_file(1'b0, 1'b1, 0);
        // trailing bytes after the decision are dropped
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, PCM_FORMAT, 16'd1, 32'd8000, PCM_BITS);
        put_chunk_head(TAG_DATA, 32'hFFFF_FFFF);
        put_half(16'hA5C3);
        emit_file(1'b1, 1'b1, 0);
        // fmt with extra bytes, odd chunk, empty chunk
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd18, PCM_FORMAT, 16'hFFFF, 32'hFFFF_FFFF, PCM_BITS);
        put_unknown_chunk(3);
        put_unknown_chunk(0);
        put_chunk_head(TAG_DATA, 32'h1234_5678);
        emit_file(1'b1, 1'b1, 0);
        // header faults; RIFF wins over WAVE
        put_header(TAG_RIFF ^ 32'h0100_0000, TAG_WAVE);
        put_chunk_head(TAG_DATA, 32'd0);
        emit_file(1'b1, 1'b1, 0);
        put_header(TAG_RIFF, TAG_WAVE ^ 32'h8000_0000);
        put_chunk_head(TAG_DATA, 32'd0);
        emit_file(1'b1, 1'b1, 0);
        put_header(32'h0, 32'hFFFF_FFFF);
        emit_file(1'b1, 1'b1, 0);
        // short header, single byte file
        put_header(TAG_RIFF, TAG_WAVE);
        emit_file(1'b1, 1'b1, 5);
        queue_byte(8'hFF, 1'b1, 1'b1);
        // not PCM, not 16-bit
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'h0003, 16'd6, 32'd48000, PCM_BITS);
        put_chunk_head(TAG_DATA, 32'd4);
        emit_file(1'b1, 1'b1, 0);
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, PCM_FORMAT, 16'd2, 32'd22050, 16'd8);
        put_chunk_head(TAG_DATA, 32'd4);
        emit_file(1'b1, 1'b1, 0);
        // truncated fmt body
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, PCM_FORMAT, 16'd1, 32'd8000, PCM_BITS);
        emit_file(1'b1, 1'b1, 25);
        // no data: ends after a skipped chunk, ends inside a chunk header
        put_header(TAG_RIFF, TAG_WAVE);
        put_unknown_chunk(4);
        emit_file(1'b1, 1'b1, 0);
        put_header(TAG_RIFF, TAG_WAVE);
        put_chunk_head(TAG_DATA, 32'd0);
        emit_file(1'b1, 1'b1, 15);
        // fmt size below 16
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd4, PCM_FORMAT, 16'd3, 32'd11025, PCM_BITS);
        put_chunk_head(TAG_DATA, 32'd64);
        emit_file(1'b1, 1'b1, 0);
        // restart mid-file, then two fmt chunks
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, PCM_FORMAT, 16'd8, 32'd96000, PCM_BITS);
        emit_file(1'b1, 1'b0, 30);
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, PCM_FORMAT, 16'd3, 32'd1000, PCM_BITS);
        put_fmt(32'd16, PCM_FORMAT, 16'd4, 32'd2000, PCM_BITS);
        put_chunk_head(TAG_DATA, 32'd2);
        emit_file(1'b1, 1'b1, 0);

        wait_idle();
        write_regs(16'hFFFF, 32'hFFFF_FFFF);
        put_header(TAG_RIFF, TAG_WAVE);
        put_chunk_head(TAG_DATA, 32'd8);
        emit_file(1'b1, 1'b1, 0);
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'h0000, 16'd9, 32'd96000, PCM_BITS);
        put_chunk_head(TAG_DATA, 32'd8);
        emit_file(1'b1, 1'b1, 0);
        // register write mid-file: fmt values stay
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, PCM_FORMAT, 16'd5, 32'd1234, PCM_BITS);
        emit_file(1'b1, 1'b0, 0);
        wait_idle();
        write_regs(16'd0, 32'd0);
        put_chunk_head(TAG_DATA, 32'h0000_0100);
        emit_file(1'b0, 1'b1, 0);
        // register write mid-file: defaults follow
        put_header(TAG_RIFF, TAG_WAVE);
        emit_file(1'b1, 1'b0, 0);
        wait_idle();
        write_regs(16'd7, 32'd9);
        put_chunk_head(TAG_DATA, 32'd1);
        emit_file(1'b0, 1'b1, 0);

        // random files: receiver idles more, then sender, then neither
        for (int sub = 0; sub < 3; sub++)
        begin
            wait_idle();
            send_idle_pct = (sub == 0) ? 35 : (sub == 1) ? 72 : 0;
            recv_idle_pct = (sub == 0) ? 72 : (sub == 1) ? 35 : 0;
            case (sub)
                1: write_regs(16'h0000, 32'h0000_0000);
                2: write_regs(16'hFFFF, 32'hFFFF_FFFF);
                default: write_regs(16'($urandom), $urandom);
            endcase
            start = bytes_queued;
            while (bytes_queued - start < 50)
                gen_random_file();
        end

        wait_idle();
        if (expected_results.size() != 0)
        begin
            $error("%0d result items never arrived", expected_results.size());
            failures++;
        end
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/wrp_pkg.sv
sv/wrp_channels.sv
sv/wrp_in_stage.sv
sv/wrp_parse_core.sv
sv/wrp_out_stage.sv
sv/wav_riff_header_parser_top.sv
sv/wrp_checker.sv
dv/wav_riff_header_parser_top_tb.sv
